// ----- rtl/tlvp_pkg.sv -----
// Package for the tag-length-value parser core.
// Holds the beat payload types, phase codes, tag and status codes and the tag name text.
// No dependencies.
package tlvp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [1:0]  tag_id;
      logic [63:0] record_length;
      logic [31:0] data_offset;
      logic [5:0]  entry_index;
      logic        done_res;
      logic [1:0]  status;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type req;
   } in_item_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } parse_out_type;

   typedef enum logic [2:0] {
      PH_NAME = 3'b001,
      PH_LEN  = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   localparam int TAG_COUNT = 3;

   localparam logic [1:0] TAG_HEADER   = 2'd0;
   localparam logic [1:0] TAG_BOOKMARK = 2'd1;
   localparam logic [1:0] TAG_EXCLUDE  = 2'd2;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_UNKNOWN_TAG = 2'd1;
   localparam logic [1:0] ST_TRUNCATED   = 2'd2;
   localparam logic [1:0] ST_TOO_MANY    = 2'd3;

   localparam logic [63:0] HEADER_TEXT   = "HEADER  ";
   localparam logic [63:0] BOOKMARK_TEXT = "BOOKMARK";
   localparam logic [63:0] EXCLUDE_TEXT  = "EXCLUDE ";

   localparam logic [2:0] LEN_LAST_BYTE = 3'd7;

   function automatic logic [7:0] tag_char(input logic [1:0] id, input logic [2:0] k);
      logic [63:0] text;
      unique case (id)
         TAG_HEADER:   text = HEADER_TEXT;
         TAG_BOOKMARK: text = BOOKMARK_TEXT;
         default:      text = EXCLUDE_TEXT;
      endcase
      return text[{LEN_LAST_BYTE - k, 3'b000} +: 8];
   endfunction

endpackage

// ----- rtl/tlvp_in_stage.sv -----
// Input register of the tag-length-value parser core.
// Depends on tlvp_pkg for the request beat type.
module tlvp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tlvp_pkg::req_type     req_payload,
   input  logic                  advance,
   output tlvp_pkg::in_item_type item
);

   logic              valid_ff, valid_in;
   tlvp_pkg::req_type req_ff;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
   end

   assign item.valid = valid_ff;
   assign item.req   = req_ff;

endmodule

// ----- rtl/tlvp_parse.sv -----
// Parse engine of the tag-length-value parser core: buffer state and one-byte step.
// Depends on tlvp_pkg for beat types, phase codes, tag text and status codes.
module tlvp_parse #(
   parameter int MAX_ENTRIES = 64,
   parameter int NAME_BYTES  = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tlvp_pkg::in_item_type   item,
   input  logic                    advance,
   output tlvp_pkg::parse_out_type result
);

   localparam int EntryCntW = $clog2(MAX_ENTRIES + 1);
   localparam logic [EntryCntW-1:0] MaxCnt = EntryCntW'(MAX_ENTRIES);
   localparam logic [2:0] NameLast = 3'(NAME_BYTES - 1);

   tlvp_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic [2:0]           flags_ff, flags_in;
   logic [63:0]          len_ff, len_in;
   logic [63:0]          rem_ff, rem_in;
   logic [EntryCntW-1:0] entries_ff, entries_in;
   logic [31:0]          pos_ff, pos_in;
   logic                 stopped_ff, stopped_in;
   logic [1:0]           tag_ff, tag_in;

   logic [7:0]  b;
   logic        last;
   logic [31:0] pos_next;
   logic [63:0] len_full;
   logic [63:0] rem_dec;
   logic [2:0]  match;
   logic [2:0]  flags_new;
   logic        entry, done;
   logic [1:0]  st;

   assign b    = item.req.data_byte;
   assign last = item.req.last_byte;

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      flags_in   = flags_ff;
      len_in     = len_ff;
      rem_in     = rem_ff;
      entries_in = entries_ff;
      pos_in     = pos_ff;
      stopped_in = stopped_ff;
      tag_in     = tag_ff;
      entry      = 1'b0;
      done       = 1'b0;
      st         = tlvp_pkg::ST_OK;
      result     = '0;
      pos_next   = (pos_ff == 32'hFFFF_FFFF) ? pos_ff : pos_ff + 32'd1;
      len_full   = {b, len_ff[63:8]};
      rem_dec    = (rem_ff != 64'd0) ? rem_ff - 64'd1 : rem_ff;
      for (int i = 0; i < tlvp_pkg::TAG_COUNT; i++) begin
         match[i] = (b == tlvp_pkg::tag_char(2'(i), cnt_ff));
      end
      flags_new  = flags_ff & match;

      if (!stopped_ff) begin
         pos_in = pos_next;
         unique case (phase_ff)
            tlvp_pkg::PH_LEN: begin
               if (cnt_ff == tlvp_pkg::LEN_LAST_BYTE) begin
                  cnt_in = 3'd0;
                  if (entries_ff >= MaxCnt) begin
                     done       = 1'b1;
                     st         = tlvp_pkg::ST_TOO_MANY;
                     stopped_in = 1'b1;
                  end else begin
                     entry      = 1'b1;
                     entries_in = entries_ff + 1'b1;
                     rem_in     = len_full;
                     phase_in   = (len_full == 64'd0) ? tlvp_pkg::PH_NAME : tlvp_pkg::PH_DATA;
                     flags_in   = 3'b111;
                  end
                  len_in = 64'd0;
               end else begin
                  cnt_in = cnt_ff + 3'd1;
                  len_in = len_full;
               end
            end
            tlvp_pkg::PH_DATA: begin
               rem_in = rem_dec;
               if (rem_dec == 64'd0) begin
                  phase_in = tlvp_pkg::PH_NAME;
                  cnt_in   = 3'd0;
                  flags_in = 3'b111;
               end
            end
            default: begin
               flags_in = flags_new;
               if (cnt_ff >= NameLast) begin
                  cnt_in = 3'd0;
                  if (flags_new == 3'b000) begin
                     done       = 1'b1;
                     st         = tlvp_pkg::ST_UNKNOWN_TAG;
                     stopped_in = 1'b1;
                  end else begin
                     tag_in   = flags_new[0] ? tlvp_pkg::TAG_HEADER :
                                (flags_new[1] ? tlvp_pkg::TAG_BOOKMARK : tlvp_pkg::TAG_EXCLUDE);
                     phase_in = tlvp_pkg::PH_LEN;
                     len_in   = 64'd0;
                  end
               end else begin
                  cnt_in = cnt_ff + 3'd1;
               end
            end
         endcase

         if (last && !done) begin
            done = 1'b1;
            if (phase_in == tlvp_pkg::PH_LEN ||
                (phase_in != tlvp_pkg::PH_DATA && cnt_in != 3'd0)) begin
               st = tlvp_pkg::ST_TRUNCATED;
            end
         end

         result.valid           = entry || done;
         result.rsp.entry_valid = entry;
         result.rsp.done_res    = done;
         result.rsp.status      = st;
         result.rsp.entry_count = 7'(entries_in);
         if (entry) begin
            result.rsp.tag_id        = tag_ff;
            result.rsp.record_length = len_full;
            result.rsp.data_offset   = pos_next;
            result.rsp.entry_index   = 6'(entries_ff);
         end
      end

      if (last) begin
         phase_in   = tlvp_pkg::PH_NAME;
         cnt_in     = 3'd0;
         flags_in   = 3'b111;
         len_in     = 64'd0;
         rem_in     = 64'd0;
         entries_in = '0;
         pos_in     = 32'd0;
         stopped_in = 1'b0;
         tag_in     = tlvp_pkg::TAG_HEADER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tlvp_pkg::PH_NAME;
         cnt_ff     <= 3'd0;
         flags_ff   <= 3'b111;
         len_ff     <= 64'd0;
         rem_ff     <= 64'd0;
         entries_ff <= '0;
         pos_ff     <= 32'd0;
         stopped_ff <= 1'b0;
         tag_ff     <= tlvp_pkg::TAG_HEADER;
      end else if (advance) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         flags_ff   <= flags_in;
         len_ff     <= len_in;
         rem_ff     <= rem_in;
         entries_ff <= entries_in;
         pos_ff     <= pos_in;
         stopped_ff <= stopped_in;
         tag_ff     <= tag_in;
      end
   end

endmodule

// ----- rtl/tlvp_out_stage.sv -----
// Result register of the tag-length-value parser core.
// Depends on tlvp_pkg for the result beat type.
module tlvp_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  tlvp_pkg::parse_out_type result,
   input  logic                    advance,
   output logic                    out_free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tlvp_pkg::rsp_type       rsp_payload
);

   logic              valid_ff, valid_in;
   tlvp_pkg::rsp_type rsp_ff;
   logic              load;

   assign load     = advance && result.valid;
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= result.rsp;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/tag_length_value_parser_core.sv -----
// Tag-length-value parser core. Takes one buffer byte per beat and reports each record
// header (tag, length, data offset, index) and the end-of-buffer status. A new byte is
// accepted every cycle while the result side is not stalled; each byte passes through an
// input register, one parse step and a result register. Only a held result beat
// (rsp_ready low) stalls the input side. No clearing pass after reset.
module tag_length_value_parser_core #(
   parameter int MAX_ENTRIES = 64,
   parameter int NAME_BYTES  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlvp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlvp_pkg::rsp_type rsp_payload
);

   tlvp_pkg::in_item_type   item;
   tlvp_pkg::parse_out_type result;
   logic                    out_free;
   logic                    advance;

   assign advance = item.valid && out_free;

   tlvp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .item        (item)
   );

   tlvp_parse #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NAME_BYTES  (NAME_BYTES)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   tlvp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .result      (result),
      .advance     (advance),
      .out_free    (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/tlvp_checker.sv -----
// Port-level checker for the tag-length-value parser core, bound to the top level.
// Depends on tlvp_pkg for the beat types and status codes.
module tlvp_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tlvp_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_rsp_meaningful: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.entry_valid || rsp_payload.done_res)
      else $error("result beat carries neither entry nor done");

   a_entry_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.entry_valid |->
         rsp_payload.tag_id == 2'd0 && rsp_payload.record_length == 64'd0 &&
         rsp_payload.data_offset == 32'd0 && rsp_payload.entry_index == 6'd0)
      else $error("entry fields set without an entry");

   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.done_res |-> rsp_payload.status == tlvp_pkg::ST_OK)
      else $error("status set without done");

   a_entry_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.entry_valid |->
         rsp_payload.entry_count[5:0] == rsp_payload.entry_index + 6'd1)
      else $error("entry count does not follow entry index");

endmodule

bind tag_length_value_parser_core tlvp_checker u_tlvp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ----- dv/testbench.sv -----
// Testbench for tag_length_value_parser_core: streams directed and random tagged buffers
// and checks every result beat against an in-bench parse of the same bytes.
// Depends on tlvp_pkg and the core RTL.
module testbench;

   localparam int MAX_ENTRIES  = 64;
   localparam int NAME_BYTES   = 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 20;
   localparam int ITEM_TARGET  = 1450;

   typedef struct packed {
      tlvp_pkg::req_type beat;
      logic              drain;
   } queued_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tlvp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tlvp_pkg::rsp_type rsp_payload;

   tag_length_value_parser_core #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .NAME_BYTES (NAME_BYTES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser state mirrored in the bench
   tlvp_pkg::phase_type scan_phase;
   logic [2:0]          field_count;
   logic [2:0]          match_flags;
   logic [63:0]         length_acc;
   logic [63:0]         data_left;
   int unsigned         entry_total;
   logic [31:0]         position;
   logic                halted;
   logic [1:0]          tag_sel;
   logic [63:0]         name_text [tlvp_pkg::TAG_COUNT];

   tlvp_pkg::rsp_type expected_rsps [$];
   queued_byte_type   pending_beats [$];
   logic [7:0]        buffer_bytes [$];

   int  useful_items = 0;
   int  total_beats = 0;
   int  accepted_count = 0;
   int  results_checked = 0;
   int  entries_checked = 0;
   int  status_hits [4];
   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  calm_left [2];
   bit  req_beat_done = 1'b0;
   bit  drain_next = 1'b0;

   task automatic restart_parse();
      scan_phase  = tlvp_pkg::PH_NAME;
      field_count = '0;
      match_flags = '1;
      length_acc  = '0;
      data_left   = '0;
      entry_total = 0;
      position    = '0;
      halted      = 1'b0;
      tag_sel     = tlvp_pkg::TAG_HEADER;
   endtask

   task automatic parse_byte(input tlvp_pkg::req_type beat);
      tlvp_pkg::rsp_type r;
      logic [2:0]        k;
      bit                has_entry;
      bit                has_done;
      r = '0;
      has_entry = 1'b0;
      has_done = 1'b0;
      if (halted) begin
         if (beat.last_byte)
            restart_parse();
         return;
      end
      if (position != '1)
         position = position + 32'd1;
      k = field_count;
      unique case (scan_phase)
         tlvp_pkg::PH_LEN: begin
            length_acc = length_acc | ({56'd0, beat.data_byte} << (8 * k));
            if (k == tlvp_pkg::LEN_LAST_BYTE) begin
               field_count = '0;
               if (entry_total >= MAX_ENTRIES) begin
                  has_done = 1'b1;
                  r.status = tlvp_pkg::ST_TOO_MANY;
                  halted = 1'b1;
               end else begin
                  has_entry = 1'b1;
                  r.tag_id = tag_sel;
                  r.record_length = length_acc;
                  r.data_offset = position;
                  r.entry_index = entry_total[5:0];
                  entry_total++;
                  data_left = length_acc;
                  scan_phase = (length_acc == 0) ? tlvp_pkg::PH_NAME : tlvp_pkg::PH_DATA;
                  match_flags = '1;
               end
               length_acc = '0;
            end else begin
               field_count = k + 3'd1;
            end
         end
         tlvp_pkg::PH_DATA: begin
            if (data_left != 0)
               data_left = data_left - 64'd1;
            if (data_left == 0) begin
               scan_phase = tlvp_pkg::PH_NAME;
               field_count = '0;
               match_flags = '1;
            end
         end
         default: begin
            for (int i = 0; i < tlvp_pkg::TAG_COUNT; i++)
               if (beat.data_byte != name_text[i][(7 - k) * 8 +: 8])
                  match_flags[i] = 1'b0;
            if (k == NAME_BYTES - 1) begin
               field_count = '0;
               if (match_flags == 0) begin
                  has_done = 1'b1;
                  r.status = tlvp_pkg::ST_UNKNOWN_TAG;
                  halted = 1'b1;
               end else begin
                  tag_sel = match_flags[0] ? tlvp_pkg::TAG_HEADER :
                            (match_flags[1] ? tlvp_pkg::TAG_BOOKMARK : tlvp_pkg::TAG_EXCLUDE);
                  scan_phase = tlvp_pkg::PH_LEN;
                  length_acc = '0;
               end
            end else begin
               field_count = k + 3'd1;
            end
         end
      endcase
      if (beat.last_byte && !has_done) begin
         has_done = 1'b1;
         if (scan_phase == tlvp_pkg::PH_LEN ||
             (scan_phase != tlvp_pkg::PH_DATA && field_count != 0))
            r.status = tlvp_pkg::ST_TRUNCATED;
         else
            r.status = tlvp_pkg::ST_OK;
      end
      if (has_entry || has_done) begin
         r.entry_valid = has_entry;
         r.done_res = has_done;
         r.entry_count = entry_total[6:0];
         expected_rsps.push_back(r);
      end
      if (beat.last_byte)
         restart_parse();
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endtask

   function automatic int idle_length(input int side);
      int r;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r < 2) begin
         calm_left[side] = $urandom_range(40, 150);
         return 0;
      end else if (r < 110) begin
         return 0;
      end else if (r < 180) begin
         return $urandom_range(1, 3);
      end else if (r < 195) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 30);
   endfunction

   task automatic add_name(input int id);
      for (int k = 0; k < NAME_BYTES; k++)
         buffer_bytes.push_back(name_text[id][(7 - k) * 8 +: 8]);
   endtask

   task automatic add_header(input int id, input logic [63:0] len);
      add_name(id);
      for (int k = 0; k < 8; k++)
         buffer_bytes.push_back(len[8 * k +: 8]);
   endtask

   task automatic add_random(input int count);
      for (int i = 0; i < count; i++)
         buffer_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic flush_buffer(input int counted);
      queued_byte_type item;
      bit              drain;
      drain = drain_next || ($urandom_range(0, 19) == 0);
      drain_next = 1'b0;
      for (int i = 0; i < buffer_bytes.size(); i++) begin
         item.beat.data_byte = buffer_bytes[i];
         item.beat.last_byte = (i == buffer_bytes.size() - 1);
         item.drain = drain && (i == 0);
         pending_beats.push_back(item);
      end
      useful_items += counted;
      buffer_bytes.delete();
   endtask

   task automatic make_random_buffer();
      int          kind;
      int          records;
      int          id;
      int          spot;
      int          count;
      int          counted;
      logic [63:0] len;
      kind = $urandom_range(0, 99);
      records = $urandom_range(0, 3);
      for (int i = 0; i < records; i++) begin
         len = 64'($urandom_range(0, 4));
         add_header($urandom_range(0, 2), len);
         add_random(int'(len));
      end
      id = $urandom_range(0, 2);
      if (kind < 55) begin
         if ($urandom_range(0, 3) == 0) begin
            len = {$urandom, $urandom};
            add_header(id, len);
            add_random($urandom_range(0, 3));
         end else begin
            len = 64'($urandom_range(0, 5));
            add_header(id, len);
            add_random(int'(len));
         end
         counted = buffer_bytes.size();
      end else if (kind < 72) begin
         add_header(id, {$urandom, $urandom});
         repeat ($urandom_range(1, 15))
            buffer_bytes.delete(buffer_bytes.size() - 1);
         counted = buffer_bytes.size();
      end else if (kind < 88) begin
         add_name(id);
         spot = buffer_bytes.size() - $urandom_range(1, NAME_BYTES);
         buffer_bytes[spot] = buffer_bytes[spot] ^ 8'($urandom_range(1, 255));
         counted = buffer_bytes.size();
         add_random($urandom_range(0, 6));
      end else begin
         count = $urandom_range(1, 20);
         counted = buffer_bytes.size() + ((count < NAME_BYTES) ? count : NAME_BYTES);
         add_random(count);
      end
      flush_buffer(counted);
   endtask

   task automatic make_full_table_buffer();
      int          counted;
      logic [63:0] len;
      counted = 0;
      for (int i = 0; i <= MAX_ENTRIES; i++) begin
         len = 64'($urandom_range(0, 3) == 0);
         add_header($urandom_range(0, 2), len);
         if (i == MAX_ENTRIES)
            counted = buffer_bytes.size();
         add_random(int'(len));
      end
      add_header($urandom_range(0, 2), 64'd0);
      flush_buffer(counted);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_beat_done) begin
         // hold until accepted
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap--;
      end else if (pending_beats.size() == 0 ||
                   (pending_beats[0].drain && expected_rsps.size() != 0)) begin
         req_valid <= 1'b0;
      end else begin
         req_valid <= 1'b1;
         req_payload <= pending_beats[0].beat;
         pending_beats.delete(0);
         send_gap = idle_length(0);
      end
      req_beat_done = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = idle_length(1);
      end
   end

   always @(posedge clock) begin : monitor
      tlvp_pkg::rsp_type want;
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            parse_byte(req_payload);
            accepted_count++;
            req_beat_done = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               error_count++;
               $display("%0t: result beat with nothing expected, expected none, actual %0h",
                        $time, rsp_payload);
            end else begin
               want = expected_rsps.pop_front();
               check_field("entry_valid", 64'(want.entry_valid),
                           64'(rsp_payload.entry_valid));
               check_field("tag_id", 64'(want.tag_id), 64'(rsp_payload.tag_id));
               check_field("record_length", want.record_length, rsp_payload.record_length);
               check_field("data_offset", 64'(want.data_offset),
                           64'(rsp_payload.data_offset));
               check_field("entry_index", 64'(want.entry_index),
                           64'(rsp_payload.entry_index));
               check_field("done_res", 64'(want.done_res), 64'(rsp_payload.done_res));
               check_field("status", 64'(want.status), 64'(rsp_payload.status));
               check_field("entry_count", 64'(want.entry_count),
                           64'(rsp_payload.entry_count));
               results_checked++;
               if (want.entry_valid)
                  entries_checked++;
               if (want.done_res)
                  status_hits[want.status]++;
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timed out, %0d of %0d beats accepted, %0d results outstanding",
               $time, accepted_count, total_beats, expected_rsps.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      name_text[0] = tlvp_pkg::HEADER_TEXT;
      name_text[1] = tlvp_pkg::BOOKMARK_TEXT;
      name_text[2] = tlvp_pkg::EXCLUDE_TEXT;
      calm_left[0] = 0;
      calm_left[1] = 0;
      for (int i = 0; i < 4; i++)
         status_hits[i] = 0;
      restart_parse();

      // header ending on the last byte, all-ones length
      add_header(int'(tlvp_pkg::TAG_BOOKMARK), '1);
      flush_buffer(16);
      // unknown name completing on the last byte
      buffer_bytes.push_back(8'h00);
      add_random(7);
      flush_buffer(8);
      // lone byte: truncated name
      buffer_bytes.push_back(8'hFF);
      flush_buffer(1);

      drain_next = 1'b1;
      while (useful_items < ITEM_TARGET) begin
         if (useful_items > 300 && useful_items < 400) begin
            make_full_table_buffer();
            drain_next = 1'b1;
         end else begin
            make_random_buffer();
         end
      end
      total_beats = pending_beats.size();

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      while (accepted_count < total_beats || expected_rsps.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d beats sent, %0d result beats checked, %0d of them entries", total_beats,
               results_checked, entries_checked);
      $display("buffer ends: %0d ok, %0d unknown tag, %0d truncated, %0d table full",
               status_hits[tlvp_pkg::ST_OK], status_hits[tlvp_pkg::ST_UNKNOWN_TAG],
               status_hits[tlvp_pkg::ST_TRUNCATED], status_hits[tlvp_pkg::ST_TOO_MANY]);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
